>>> hdl/u8u16_pkg.sv
// Package for the UTF-8 to UTF-16 decoder: result types and decode constants.
// No dependencies; imported by the top, decode, outbuf and testbench files.
`timescale 1ns / 1ps

package u8u16_pkg;

    // Decoded value: 21 bits cover the whole UTF-16 range, plus an overflow flag.
    localparam int unsigned ACC_W = 21;

    localparam logic [ACC_W-1:0] CODE_LIMIT   = 21'h110000;
    localparam logic [15:0]      SURR_HI_BASE = 16'hD800;
    localparam logic [15:0]      SURR_LO_BASE = 16'hDC00;
    localparam logic [ACC_W-1:0] SUPP_BASE    = 21'h010000;

    // One result item on the output channel.
    typedef struct packed {
        logic [15:0] code_unit;
        logic        unit_valid;
        logic        string_done;
        logic        string_failed;
        logic        run_end;
    } t_result;

    // Everything one input item produces: zero, one or two results.
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_dec_out;

endpackage

>>> hdl/u8u16_byte_if.sv
// Input channel of the decoder: one UTF-8 byte per item with a string-end flag.
// No dependencies.
`timescale 1ns / 1ps

interface u8u16_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       string_end;

    modport source (output valid, output data_byte, output string_end, input ready);
    modport sink   (input valid, input data_byte, input string_end, output ready);
endinterface

>>> hdl/u8u16_unit_if.sv
// Output channel of the decoder: one UTF-16 code unit result per item.
// No dependencies.
`timescale 1ns / 1ps

interface u8u16_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        string_done;
    logic        string_failed;
    logic        run_end;

    modport source (output valid, output code_unit, output unit_valid, output string_done,
                    output string_failed, output run_end, input ready);
    modport sink   (input valid, input code_unit, input unit_valid, input string_done,
                    input string_failed, input run_end, output ready);
endinterface

>>> hdl/utf8_to_utf16_decoder_top.sv
// Top level of the lenient UTF-8 to UTF-16 decoder.
// Depends on u8u16_pkg, the two channel interfaces, u8u16_decode and u8u16_outbuf.
`timescale 1ns / 1ps

// Usage:
//   i_byte carries one UTF-8 byte per item, string_end set on a string's last byte.
//   o_unit carries result items: a UTF-16 code unit (unit_valid set), or, for a
//   string whose last byte produced nothing, an empty result (unit_valid clear).
//   run_end marks the last result caused by a byte; string_done marks the final
//   result of a string and string_failed then reports a stray continuation byte
//   or a value at or above 0x110000.
// Path: a byte accepted into the input register is decoded combinationally and
//   its first result is presented on o_unit from the result register.
// Throughput: one byte per cycle while o_unit.ready is high. A byte that
//   completes a supplementary character yields a surrogate pair, which holds the
//   result register until both halves are taken; that register sets the rate.
// Reset (i_rst_n low, synchronous): clear the input valid flag, the result count
//   and the sequence state; no stale result appears.
// Stall: while o_unit.ready is low the result register holds its item; the
//   input register still takes one more byte, then i_byte.ready drops.
module utf8_to_utf16_decoder_top
    import u8u16_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    u8u16_byte_if.sink    i_byte,
    u8u16_unit_if.source  o_unit
);

    // Decode stage to result register
    logic     load;
    logic     load_ok;
    t_dec_out dec;

    u8u16_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (i_byte),
        .i_load_ok (load_ok),
        .o_load    (load),
        .o_dec     (dec)
    );

    // Hold the results of one byte and hand them out in order
    u8u16_outbuf u_outbuf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (load),
        .i_dec     (dec),
        .o_load_ok (load_ok),
        .o_unit    (o_unit)
    );

`ifndef SYNTHESIS
    // The second half of a surrogate pair is ready right behind the first
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_unit.valid && !o_unit.run_end) |=> o_unit.valid)
        else $error("second result of a byte not presented");

    // The end of a string is always the last result of its byte
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_unit.valid && o_unit.string_done) |-> o_unit.run_end)
        else $error("string_done on a result that is not the last of its byte");

    // An empty result only carries the end of a string
    a_empty_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_unit.valid && !o_unit.unit_valid) |->
            (o_unit.string_done && o_unit.code_unit == 16'h0000))
        else $error("empty result without string_done");

    // Failure is reported only with string_done
    a_fail_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_unit.valid && o_unit.string_failed) |-> o_unit.string_done)
        else $error("string_failed without string_done");
`endif

endmodule

>>> hdl/u8u16_decode.sv
// Input register and per-byte decode: sequence state, flush and surrogate split.
// Depends on u8u16_pkg and u8u16_byte_if.
`timescale 1ns / 1ps

module u8u16_decode
    import u8u16_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    u8u16_byte_if.sink   i_byte,
    input  logic         i_load_ok,
    output logic         o_load,
    output t_dec_out     o_dec
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_end;

    logic [2:0]       r_pend;
    logic [ACC_W-1:0] r_acc;
    logic             r_ovf;
    logic             r_fail;

    logic [2:0]       n_pend;
    logic [ACC_W-1:0] n_acc;
    logic             n_ovf;
    logic             n_fail;

    logic [2:0]       pend_a;
    logic [ACC_W-1:0] acc_a;
    logic             ovf_a;
    logic             fail_a;
    logic             flush_a;
    logic             single_a;
    logic             is_cont;
    logic             flush_req;
    logic             small_val;
    logic             range_fail;
    logic             fail_f;
    logic [ACC_W-1:0] supp;
    logic [1:0]       k;
    logic [15:0]      u0;
    logic [15:0]      u1;
    t_result          res0;
    t_result          res1;
    logic             advance;

    assign advance      = r_in_valid && i_load_ok;
    assign o_load       = advance;
    assign i_byte.ready = !r_in_valid || i_load_ok;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
        if (i_byte.ready && i_byte.valid) begin
            r_in_byte <= i_byte.data_byte;
            r_in_end  <= i_byte.string_end;
        end
    end

    assign is_cont = (r_in_byte[7:6] == 2'b10);

    // Step the sequence state with this byte
    always_comb begin
        pend_a   = r_pend;
        acc_a    = r_acc;
        ovf_a    = r_ovf;
        fail_a   = r_fail;
        flush_a  = 1'b0;
        single_a = 1'b0;
        if (r_fail) begin
            // drop the byte
        end else if (r_pend != 3'd0) begin
            if (is_cont) begin
                acc_a   = {r_acc[ACC_W-7:0], r_in_byte[5:0]};
                ovf_a   = r_ovf | (|r_acc[ACC_W-1:ACC_W-6]);
                pend_a  = r_pend - 3'd1;
                flush_a = (pend_a == 3'd0);
            end else begin
                flush_a = 1'b1;
            end
        end else if (!r_in_byte[7]) begin
            single_a = 1'b1;
        end else if (is_cont) begin
            fail_a = 1'b1;
        end else begin
            ovf_a = 1'b0;
            unique case (r_in_byte[5:2]) inside
                4'b0???: begin
                    pend_a = 3'd1;
                    acc_a  = {{(ACC_W-5){1'b0}}, r_in_byte[4:0]};
                end
                4'b10??: begin
                    pend_a = 3'd2;
                    acc_a  = {{(ACC_W-4){1'b0}}, r_in_byte[3:0]};
                end
                4'b110?: begin
                    pend_a = 3'd3;
                    acc_a  = {{(ACC_W-3){1'b0}}, r_in_byte[2:0]};
                end
                4'b1110: begin
                    pend_a = 3'd4;
                    acc_a  = {{(ACC_W-2){1'b0}}, r_in_byte[1:0]};
                end
                default: begin
                    pend_a = 3'd5;
                    acc_a  = {{(ACC_W-2){1'b0}}, r_in_byte[1:0]};
                end
            endcase
        end
    end

    // Flush the gathered value: on completion, a wrong byte, or the string end
    assign flush_req  = flush_a || (r_in_end && !fail_a && pend_a != 3'd0);
    assign small_val  = !ovf_a && (acc_a[ACC_W-1:16] == '0);
    assign range_fail = flush_req && (ovf_a || acc_a >= CODE_LIMIT);
    assign fail_f     = fail_a | range_fail;
    assign supp       = acc_a - SUPP_BASE;

    always_comb begin
        k  = 2'd0;
        u0 = 16'h0000;
        u1 = 16'h0000;
        if (single_a) begin
            k  = 2'd1;
            u0 = {8'h00, r_in_byte};
        end else if (flush_req && !range_fail) begin
            if (small_val) begin
                k  = 2'd1;
                u0 = acc_a[15:0];
            end else begin
                k  = 2'd2;
                u0 = SURR_HI_BASE + {6'b0, supp[19:10]};
                u1 = SURR_LO_BASE + {6'b0, supp[9:0]};
            end
        end
    end

    // Assemble results; the last one carries run_end and the string status
    always_comb begin
        res0 = '{code_unit: u0, unit_valid: (k != 2'd0),
                 string_done: 1'b0, string_failed: 1'b0, run_end: 1'b0};
        res1 = '{code_unit: u1, unit_valid: 1'b1,
                 string_done: 1'b0, string_failed: 1'b0, run_end: 1'b0};
        o_dec.count = k;
        if (k == 2'd2) begin
            res1.run_end       = 1'b1;
            res1.string_done   = r_in_end;
            res1.string_failed = r_in_end & fail_f;
        end else begin
            res0.run_end       = 1'b1;
            res0.string_done   = r_in_end;
            res0.string_failed = r_in_end & fail_f;
            if (r_in_end && k == 2'd0) begin
                o_dec.count = 2'd1;
            end
        end
        o_dec.res0 = res0;
        o_dec.res1 = res1;
    end

    always_comb begin
        if (r_in_end) begin
            n_pend = 3'd0;
            n_acc  = '0;
            n_ovf  = 1'b0;
            n_fail = 1'b0;
        end else begin
            n_pend = flush_req ? 3'd0 : pend_a;
            n_acc  = flush_req ? '0 : acc_a;
            n_ovf  = flush_req ? 1'b0 : ovf_a;
            n_fail = fail_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 3'd0;
            r_acc  <= '0;
            r_ovf  <= 1'b0;
            r_fail <= 1'b0;
        end else if (advance) begin
            r_pend <= n_pend;
            r_acc  <= n_acc;
            r_ovf  <= n_ovf;
            r_fail <= n_fail;
        end
    end

endmodule

>>> hdl/u8u16_outbuf.sv
// Result register: holds up to two results of one byte and hands them out in order.
// Depends on u8u16_pkg and u8u16_unit_if.
`timescale 1ns / 1ps

module u8u16_outbuf
    import u8u16_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  t_dec_out      i_dec,
    output logic          o_load_ok,
    u8u16_unit_if.source  o_unit
);

    t_result    r_res [2];
    logic [1:0] r_left;
    logic       r_idx;
    logic       take;
    t_result    cur;

    assign take      = o_unit.valid && o_unit.ready;
    assign o_load_ok = (r_left == 2'd0) || (r_left == 2'd1 && o_unit.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 2'd0;
            r_idx  <= 1'b0;
        end else if (i_load) begin
            r_left <= i_dec.count;
            r_idx  <= 1'b0;
        end else if (take) begin
            r_left <= r_left - 2'd1;
            r_idx  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res[0] <= i_dec.res0;
            r_res[1] <= i_dec.res1;
        end
    end

    assign cur                  = r_res[r_idx];
    assign o_unit.valid         = (r_left != 2'd0);
    assign o_unit.code_unit     = cur.code_unit;
    assign o_unit.unit_valid    = cur.unit_valid;
    assign o_unit.string_done   = cur.string_done;
    assign o_unit.string_failed = cur.string_failed;
    assign o_unit.run_end       = cur.run_end;

endmodule

>>> tb/utf8_to_utf16_decoder_top_test.sv
// Self-checking testbench for utf8_to_utf16_decoder_top: directed and random UTF-8
// strings go in, and each UTF-16 result is checked against an in-bench decoder.
// Depends on u8u16_pkg, u8u16_byte_if, u8u16_unit_if and the decoder RTL.
`timescale 1ns / 1ps

module utf8_to_utf16_decoder_top_test;
    import u8u16_pkg::*;

    // One input item: a UTF-8 byte and the flag on a string's last byte.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       string_end;
    } t_byte_item;

    logic i_clk = 1'b0;
    logic i_rst_n;

    u8u16_byte_if byte_if ();
    u8u16_unit_if unit_if ();

    utf8_to_utf16_decoder_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_if),
        .o_unit  (unit_if)
    );

    always #1 i_clk = ~i_clk;

    // Bytes waiting to be offered, and the UTF-16 results still owed by the block.
    t_byte_item byte_queue[$];
    t_result    unit_expect[$];
    t_result    byte_units[$];

    // Decoder state as the block should hold it.
    logic [2:0]  seq_left;
    logic [31:0] seq_value;
    logic        str_failed;

    int         src_idle_pct;
    int         snk_idle_pct;
    logic       hold_off;
    int         bytes_accepted;
    int         mismatches;
    t_byte_item next_byte;

    // ------------------------------------------------------------------
    // Decoder prediction
    // ------------------------------------------------------------------
    function automatic void push_unit(logic [15:0] cu, logic vld);
        t_result r;
        r            = '0;
        r.code_unit  = cu;
        r.unit_valid = vld;
        byte_units.push_back(r);
    endfunction

    // Emit the value gathered so far: one unit below 0x10000, a surrogate pair
    // up to 0x10FFFF, and nothing but a failed string beyond that.
    function automatic void flush_seq();
        logic [31:0] v;
        v        = seq_value;
        seq_left = 3'd0;
        if (v < 32'h10000) begin
            push_unit(v[15:0], 1'b1);
        end else begin
            v = v - 32'h10000;
            if (v >= 32'h100000) begin
                str_failed = 1'b1;
            end else begin
                push_unit(SURR_HI_BASE + {6'd0, v[19:10]}, 1'b1);
                push_unit(SURR_LO_BASE + {6'd0, v[9:0]}, 1'b1);
            end
        end
        seq_value = 32'd0;
    endfunction

    // Work out the results of one accepted byte and queue them as expected.
    function automatic void predict_units(logic [7:0] b, logic last);
        int last_idx;
        byte_units.delete();
        if (!str_failed) begin
            if (seq_left != 3'd0) begin
                if (b >= 8'h80 && b < 8'hC0) begin
                    seq_value = {seq_value[25:0], b[5:0]};
                    seq_left  = seq_left - 3'd1;
                    if (seq_left == 3'd0)
                        flush_seq();
                end else begin
                    // wrong continuation: drop the byte, emit the partial value
                    flush_seq();
                end
            end else if (b < 8'h80) begin
                push_unit({8'h00, b}, 1'b1);
            end else if (b < 8'hC0) begin
                // stray continuation byte
                str_failed = 1'b1;
            end else if (b < 8'hE0) begin
                seq_value = {27'd0, b[4:0]};
                seq_left  = 3'd1;
            end else if (b < 8'hF0) begin
                seq_value = {28'd0, b[3:0]};
                seq_left  = 3'd2;
            end else if (b < 8'hF8) begin
                seq_value = {29'd0, b[2:0]};
                seq_left  = 3'd3;
            end else if (b < 8'hFC) begin
                seq_value = {30'd0, b[1:0]};
                seq_left  = 3'd4;
            end else begin
                seq_value = {30'd0, b[1:0]};
                seq_left  = 3'd5;
            end
        end

        if (last) begin
            // string cut off inside a sequence: emit what was gathered
            if (!str_failed && seq_left != 3'd0)
                flush_seq();
            if (byte_units.size() == 0)
                push_unit(16'h0000, 1'b0);
            last_idx = byte_units.size() - 1;
            byte_units[last_idx].string_done   = 1'b1;
            byte_units[last_idx].string_failed = str_failed;
            seq_left   = 3'd0;
            seq_value  = 32'd0;
            str_failed = 1'b0;
        end

        if (byte_units.size() != 0) begin
            last_idx = byte_units.size() - 1;
            byte_units[last_idx].run_end = 1'b1;
        end
        foreach (byte_units[i])
            unit_expect.push_back(byte_units[i]);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    function automatic void push_byte(logic [7:0] b, logic last);
        t_byte_item it;
        it.data_byte  = b;
        it.string_end = last;
        byte_queue.push_back(it);
    endfunction

    // Build one string, mostly well-formed characters with random payload bits,
    // some cut short and some plain noise, and queue it whole. Return its length.
    function automatic int add_random_string();
        t_byte_item str[$];
        t_byte_item it;
        int         n_chars;
        int         kind;
        int         conts;
        int         keep;
        logic [7:0] lead;
        n_chars = $urandom_range(1, 6);
        repeat (n_chars) begin
            kind          = $urandom_range(0, 99);
            it.string_end = 1'b0;
            if (kind < 40) begin
                it.data_byte = 8'($urandom_range(0, 127));
                str.push_back(it);
            end else if (kind < 88) begin
                conts = (kind < 55) ? 1 : (kind < 68) ? 2 : (kind < 82) ? 3 :
                        (kind < 85) ? 4 : 5;
                case (conts)
                    1:       lead = 8'hC0 | 8'($urandom_range(0, 31));
                    2:       lead = 8'hE0 | 8'($urandom_range(0, 15));
                    3:       lead = 8'hF0 | 8'($urandom_range(0, 7));
                    4:       lead = 8'hF8 | 8'($urandom_range(0, 3));
                    default: lead = 8'hFC | 8'($urandom_range(0, 3));
                endcase
                // cut a tenth of the sequences short
                keep = ($urandom_range(0, 9) == 0) ? $urandom_range(0, conts - 1) : conts;
                it.data_byte = lead;
                str.push_back(it);
                repeat (keep) begin
                    it.data_byte = 8'h80 | 8'($urandom_range(0, 63));
                    str.push_back(it);
                end
            end else begin
                it.data_byte = 8'($urandom_range(0, 255));
                str.push_back(it);
            end
        end
        str[str.size() - 1].string_end = 1'b1;
        foreach (str[i])
            byte_queue.push_back(str[i]);
        return str.size();
    endfunction

    // ------------------------------------------------------------------
    // Byte driver: offer the next pending item once the current one is taken,
    // idling at random; predict each item at the edge that accepts it.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_if.valid <= 1'b0;
        end else begin
            if (byte_if.valid && byte_if.ready) begin
                predict_units(byte_if.data_byte, byte_if.string_end);
                bytes_accepted <= bytes_accepted + 1;
            end
            if (!byte_if.valid || byte_if.ready) begin
                if (byte_queue.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    next_byte             = byte_queue.pop_front();
                    byte_if.valid      <= 1'b1;
                    byte_if.data_byte  <= next_byte.data_byte;
                    byte_if.string_end <= next_byte.string_end;
                end else begin
                    byte_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result sink: stall at random, and hold off entirely while hold_off is set.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            unit_if.ready <= 1'b0;
        end else begin
            unit_if.ready <= !hold_off && ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each accepted result with the oldest expectation.
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && unit_if.valid && unit_if.ready) begin
            if (unit_expect.size() == 0) begin
                $error("unexpected result: code_unit 0x%0h unit_valid %0b string_done %0b",
                       unit_if.code_unit, unit_if.unit_valid, unit_if.string_done);
                mismatches++;
            end else begin
                want = unit_expect.pop_front();
                check_field("code_unit",     want.code_unit,     unit_if.code_unit);
                check_field("unit_valid",    16'(want.unit_valid),
                            16'(unit_if.unit_valid));
                check_field("string_done",   16'(want.string_done),
                            16'(unit_if.string_done));
                check_field("string_failed", 16'(want.string_failed),
                            16'(unit_if.string_failed));
                check_field("run_end",       16'(want.run_end),
                            16'(unit_if.run_end));
            end
        end
    end

    // ------------------------------------------------------------------
    // Back-pressure: once traffic is flowing, hold the sink off for a long
    // stretch so the block fills and drops i_byte.ready.
    // ------------------------------------------------------------------
    initial begin
        hold_off = 1'b0;
        wait (bytes_accepted >= 40);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Watchdog: a healthy run finishes far sooner.
    initial begin
        #400000;
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed strings, then three random phases with
    // different idling, then drain and report.
    // ------------------------------------------------------------------
    initial begin : main_seq
        int src_pct[3];
        int snk_pct[3];
        int phase_bytes;

        src_pct = '{23, 51, 0};
        snk_pct = '{51, 23, 0};

        i_rst_n            = 1'b0;
        byte_if.valid      = 1'b0;
        byte_if.data_byte  = 8'h00;
        byte_if.string_end = 1'b0;
        unit_if.ready      = 1'b0;
        seq_left           = 3'd0;
        seq_value          = 32'd0;
        str_failed         = 1'b0;
        bytes_accepted     = 0;
        mismatches         = 0;
        src_idle_pct       = src_pct[0];
        snk_idle_pct       = snk_pct[0];

        // ASCII extremes
        push_byte(8'h00, 1'b0);
        push_byte(8'h7F, 1'b1);
        // two- and three-byte characters
        push_byte(8'hC3, 1'b0);
        push_byte(8'hA9, 1'b0);
        push_byte(8'hE2, 1'b0);
        push_byte(8'h82, 1'b0);
        push_byte(8'hAC, 1'b1);
        // four-byte character: surrogate pair, string ends on the low half
        push_byte(8'hF0, 1'b0);
        push_byte(8'h9F, 1'b0);
        push_byte(8'h98, 1'b0);
        push_byte(8'h80, 1'b1);
        // value 0x110000: fail, and drop the trailing byte
        push_byte(8'hF4, 1'b0);
        push_byte(8'h90, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h41, 1'b1);
        // stray continuation byte alone in a string
        push_byte(8'hBF, 1'b1);
        // wrong continuation: partial value out, the ASCII byte dropped
        push_byte(8'hE2, 1'b0);
        push_byte(8'h41, 1'b1);
        // surrogate value passes through; string ends right after a lead byte
        push_byte(8'hED, 1'b0);
        push_byte(8'hA0, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hC0, 1'b1);
        // longest lead with all-ones payload: far out of range
        push_byte(8'hFF, 1'b0);
        repeat (4) push_byte(8'hBF, 1'b0);
        push_byte(8'hBF, 1'b1);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = src_pct[ph];
            snk_idle_pct = snk_pct[ph];
            phase_bytes  = 0;
            while (phase_bytes < 170)
                phase_bytes += add_random_string();
            // hold the next phase until every byte of this one is offered
            while (byte_queue.size() != 0)
                @(posedge i_clk);
        end

        // drain: last byte taken, then every result back, then a latency margin
        while (byte_queue.size() != 0 || byte_if.valid)
            @(posedge i_clk);
        while (unit_expect.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
